[hw/rtl/u16u8_pkg.sv]
// Shared types and constants for the UTF-16 to UTF-8 offset transcoder.
// No dependencies; the core, u16u8_build and u16u8_ser import this package.
package u16u8_pkg;

    localparam int MaxBeats = 8;
    localparam int IdxW     = $clog2(MaxBeats);
    localparam int CntW     = IdxW + 1;
    localparam int PosW     = 32;

    localparam logic KindByte   = 1'b0;
    localparam logic KindOffset = 1'b1;

    localparam logic [5:0]  SurrHighTag = 6'b110110;
    localparam logic [5:0]  SurrLowTag  = 6'b110111;
    localparam logic [20:0] SuppBase    = 21'h010000;
    localparam logic [20:0] ReplCp      = 21'h00FFFD;
    localparam logic        EmitReset   = 1'b1;

    typedef struct packed {
        logic            kind;
        logic [PosW-1:0] value;
    } t_beat;

    typedef struct packed {
        logic [CntW-1:0]             cnt;
        t_beat [MaxBeats-1:0]        beats;
    } t_run;

endpackage

[hw/rtl/u16u8_in_if.sv]
// Input channel: one UTF-16 code unit per beat with valid/ready.
// No dependencies.
interface u16u8_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        has_unit;
    logic        end_of_text;

    modport source (output valid, code_unit, has_unit, end_of_text, input ready);
    modport sink   (input valid, code_unit, has_unit, end_of_text, output ready);
endinterface

[hw/rtl/u16u8_out_if.sv]
// Output channel: one result beat (UTF-8 byte or offset entry) with valid/ready.
// No dependencies.
interface u16u8_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] value;
    logic        last_of_run;

    modport source (output valid, kind, value, last_of_run, input ready);
    modport sink   (input valid, kind, value, last_of_run, output ready);
endinterface

[hw/rtl/u16u8_cfg_if.sv]
// Configuration write channel carrying the emit_utf8 register.
// No dependencies.
interface u16u8_cfg_if;
    logic valid;
    logic ready;
    logic emit_utf8;

    modport source (output valid, emit_utf8, input ready);
    modport sink   (input valid, emit_utf8, output ready);
endinterface

[hw/rtl/utf16_to_utf8_offset_transcoder_core.sv]
// Top level of the UTF-16 to UTF-8 offset transcoder.
// Depends on u16u8_pkg, the three channel interfaces, u16u8_build and u16u8_ser.
//
// Each accepted code unit yields an offset entry (the running UTF-8 byte
// position, modulo 2^32) and, when emit_utf8 is set, its UTF-8 bytes; a high
// surrogate waits for the next unit, a valid pair gives four bytes with the
// low unit repeating the pair's offset, lone surrogates become EF BF BD, and
// end_of_text flushes a held high surrogate, gives the total byte count as a
// sentinel offset and clears the position. An item is held in the input
// register and then moves to the result register, which sends its result
// beats (0 to 8, typically 2 to 4 for BMP text) one beat per cycle while
// o_out.ready is high; the next item is decoded while the current run drains.
// Configuration writes are always taken and must only happen while the
// block is idle.
module utf16_to_utf8_offset_transcoder_core
    import u16u8_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    u16u8_in_if.sink     i_in,
    u16u8_cfg_if.sink    i_cfg,
    u16u8_out_if.source  o_out
);

    t_run run;
    logic run_load;
    logic run_ready;

    u16u8_build u_build (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (i_cfg),
        .i_run_ready (run_ready),
        .o_run_load  (run_load),
        .o_run       (run)
    );

    u16u8_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (run_load),
        .i_run   (run),
        .o_ready (run_ready),
        .o_out   (o_out)
    );

endmodule

[hw/rtl/u16u8_build.sv]
// Input register, surrogate tracking, byte position and run builder.
// Depends on u16u8_pkg, u16u8_in_if and u16u8_cfg_if.
module u16u8_build
    import u16u8_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    u16u8_in_if.sink    i_in,
    u16u8_cfg_if.sink   i_cfg,
    input  logic        i_run_ready,
    output logic        o_run_load,
    output t_run        o_run
);

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } t_enc;

    function automatic t_enc encode(input logic [20:0] cp);
        t_enc e;
        e = '0;
        if (cp < 21'h80) begin
            e.bytes[0] = cp[7:0];
            e.len      = 3'd1;
        end else if (cp < 21'h800) begin
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
            e.len      = 3'd2;
        end else if (cp < SuppBase) begin
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
            e.len      = 3'd3;
        end else begin
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
            e.len      = 3'd4;
        end
        return e;
    endfunction

    localparam t_enc ReplEnc = encode(ReplCp);

    logic            r_a_valid;
    logic [15:0]     r_unit;
    logic            r_has;
    logic            r_end;
    logic            r_emit;
    logic            r_pend;
    logic [9:0]      r_bits;
    logic [PosW-1:0] r_pos;

    logic            is_high;
    logic            is_low;
    logic            pair;
    logic            f1;
    logic            f2;
    logic            u_en;
    logic            pend_after;
    logic [20:0]     cp;
    t_enc            enc_u;
    logic [2:0]      len_u;
    logic [3:0]      small_u;
    logic [3:0]      small_all;
    logic [PosW-1:0] off1;
    logic [PosW-1:0] off2;
    logic [PosW-1:0] pos_u;
    logic            advance;
    t_run            run;
    logic [CntW-1:0] n;

    assign advance     = r_a_valid && i_run_ready;
    assign i_in.ready  = !r_a_valid || i_run_ready;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        is_high    = r_unit[15:10] == SurrHighTag;
        is_low     = r_unit[15:10] == SurrLowTag;
        pair       = r_has && r_pend && is_low;
        f1         = r_has && r_pend && !is_low;
        if (pair) begin
            cp = SuppBase + {1'b0, r_bits, r_unit[9:0]};
        end else if (is_low) begin
            cp = ReplCp;
        end else begin
            cp = {5'b0, r_unit};
        end
        u_en       = r_has && !is_high;
        enc_u      = encode(cp);
        len_u      = u_en ? enc_u.len : 3'd0;
        pend_after = r_has ? is_high : r_pend;
        f2         = r_end && pend_after;
        small_u    = (f1 ? 4'd3 : 4'd0) + {1'b0, len_u};
        small_all  = small_u + (f2 ? 4'd3 : 4'd0);
        off1       = r_pos + (f1 ? PosW'(3) : PosW'(0));
        pos_u      = r_pos + PosW'(small_u);
        off2       = r_pos + PosW'(small_all);
    end

    always_comb begin
        run = '0;
        n   = '0;
        if (f1 && r_emit) begin
            for (int i = 0; i < 3; i++) begin
                run.beats[n[IdxW-1:0]] = '{kind: KindByte, value: {24'b0, ReplEnc.bytes[i]}};
                n = n + 1'b1;
            end
        end
        if (r_has) begin
            run.beats[n[IdxW-1:0]] = '{kind: KindOffset, value: off1};
            n = n + 1'b1;
        end
        if (u_en && r_emit) begin
            for (int i = 0; i < 4; i++) begin
                if (3'(i) < enc_u.len) begin
                    run.beats[n[IdxW-1:0]] = '{kind: KindByte, value: {24'b0, enc_u.bytes[i]}};
                    n = n + 1'b1;
                end
            end
        end
        if (f2 && r_emit) begin
            for (int i = 0; i < 3; i++) begin
                run.beats[n[IdxW-1:0]] = '{kind: KindByte, value: {24'b0, ReplEnc.bytes[i]}};
                n = n + 1'b1;
            end
        end
        if (r_end) begin
            run.beats[n[IdxW-1:0]] = '{kind: KindOffset, value: off2};
            n = n + 1'b1;
        end
        run.cnt = n;
    end

    assign o_run      = run;
    assign o_run_load = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_emit    <= EmitReset;
            r_pend    <= 1'b0;
            r_bits    <= '0;
            r_pos     <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_emit <= i_cfg.emit_utf8;
            end
            if (i_in.valid && i_in.ready) begin
                r_a_valid <= 1'b1;
            end else if (advance) begin
                r_a_valid <= 1'b0;
            end
            if (advance) begin
                if (r_end) begin
                    r_pend <= 1'b0;
                    r_bits <= '0;
                    r_pos  <= '0;
                end else begin
                    r_pend <= pend_after;
                    r_pos  <= pos_u;
                    if (r_has && is_high) begin
                        r_bits <= r_unit[9:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_unit <= i_in.code_unit;
            r_has  <= i_in.has_unit;
            r_end  <= i_in.end_of_text;
        end
    end

endmodule

[hw/rtl/u16u8_ser.sv]
// Result register: holds one run of beats and sends them one per cycle while o_out.ready is high.
// Depends on u16u8_pkg and u16u8_out_if.
module u16u8_ser
    import u16u8_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_load,
    input  t_run         i_run,
    output logic         o_ready,
    u16u8_out_if.source  o_out
);

    logic                 r_valid;
    logic [CntW-1:0]      r_cnt;
    logic [IdxW-1:0]      r_idx;
    t_beat [MaxBeats-1:0] r_beats;

    logic last;
    logic fire;

    assign last    = {1'b0, r_idx} == (r_cnt - 1'b1);
    assign fire    = r_valid && o_out.ready;
    assign o_ready = !r_valid || (fire && last);

    assign o_out.valid       = r_valid;
    assign o_out.kind        = r_beats[r_idx].kind;
    assign o_out.value       = r_beats[r_idx].value;
    assign o_out.last_of_run = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
            r_cnt   <= '0;
        end else begin
            if (i_load) begin
                r_valid <= i_run.cnt != '0;
                r_cnt   <= i_run.cnt;
                r_idx   <= '0;
            end else if (fire && last) begin
                r_valid <= 1'b0;
            end else if (fire) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_beats <= i_run.beats;
        end
    end

    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ({1'b0, r_idx} < r_cnt))
        else $error("beat index beyond run length");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !last && !i_load) |=> (r_idx == $past(r_idx) + 1'b1) && r_valid)
        else $error("non-final beat did not advance index");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && last) |=> (!r_valid || r_idx == '0))
        else $error("new run did not start at first beat");

    a_load_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_ready)
        else $error("run loaded over unfinished run");

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for utf16_to_utf8_offset_transcoder_core.
// Depends on u16u8_pkg, the three channel interfaces and utf16_to_utf8_offset_transcoder_core.
// Directed rows use typed beats or a cycle-free encoder model; random texts use the model.
module tb
    import u16u8_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYC = 12;
    localparam int GAP_TOP   = 13;

    typedef enum logic {ROW_UNIT, ROW_CFG} t_row_op;

    typedef struct {
        logic        kind;
        logic [31:0] value;
        logic        last;
    } t_want_beat;

    typedef struct {
        logic [15:0] code_unit;
        logic        has_unit;
        logic        end_of_text;
    } t_unit_item;

    typedef struct {
        t_row_op     op;
        logic        emit;
        logic [15:0] code_unit;
        logic        has_unit;
        logic        end_of_text;
        int          n_want;
        t_beat       want [8];
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    u16u8_in_if  in_if ();
    u16u8_cfg_if cfg_if ();
    u16u8_out_if out_if ();

    utf16_to_utf8_offset_transcoder_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    // encoder model state
    logic        emit_on;
    logic        high_held;
    logic [9:0]  high_bits;
    logic [31:0] model_pos;

    t_want_beat  want_beats_q [$];
    t_want_beat  unit_run_q [$];
    t_want_beat  got_want;
    t_dir_row    dir_q [$];
    t_unit_item  text_q [$];
    t_beat       no_beats [8];

    int          err_cnt = 0;
    int unsigned gap_max = GAP_TOP;
    int unsigned stall_max = GAP_TOP;
    int unsigned stall_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic t_beat ofs(logic [31:0] v);
        return '{KindOffset, v};
    endfunction

    function automatic t_beat u8(int v);
        return '{KindByte, {24'b0, v[7:0]}};
    endfunction

    function automatic void queue_unit(logic [15:0] u, logic has, logic eot);
        t_unit_item it;
        it     = '{u, has, eot};
        text_q = {text_q, it};
    endfunction

    function automatic void add_beat(logic kind, logic [31:0] v);
        t_want_beat b;
        b          = '{kind, v, 1'b0};
        unit_run_q = {unit_run_q, b};
    endfunction

    function automatic void encode_code_point(logic [20:0] cp);
        logic [7:0] b [4];
        int         len;
        if (cp < 21'h80) begin
            b[0] = cp[7:0];
            len  = 1;
        end else if (cp < 21'h800) begin
            b[0] = 8'hC0 | cp[10:6];
            b[1] = 8'h80 | cp[5:0];
            len  = 2;
        end else if (cp < 21'h10000) begin
            b[0] = 8'hE0 | cp[15:12];
            b[1] = 8'h80 | cp[11:6];
            b[2] = 8'h80 | cp[5:0];
            len  = 3;
        end else begin
            b[0] = 8'hF0 | cp[20:18];
            b[1] = 8'h80 | cp[17:12];
            b[2] = 8'h80 | cp[11:6];
            b[3] = 8'h80 | cp[5:0];
            len  = 4;
        end
        if (emit_on) begin
            for (int i = 0; i < len; i++) add_beat(KindByte, {24'b0, b[i]});
        end
        model_pos = model_pos + 32'(len);
    endfunction

    function automatic void flush_held_high();
        if (high_held) begin
            encode_code_point(ReplCp);
            high_held = 1'b0;
            high_bits = '0;
        end
    endfunction

    function automatic void encode_unit(logic [15:0] u, logic has, logic eot);
        logic is_high;
        logic is_low;
        is_high = (u[15:10] == SurrHighTag);
        is_low  = (u[15:10] == SurrLowTag);
        unit_run_q.delete();
        if (has) begin
            if (high_held && is_low) begin
                high_held = 1'b0;
                add_beat(KindOffset, model_pos);
                encode_code_point(SuppBase + {high_bits, u[9:0]});
                high_bits = '0;
            end else begin
                flush_held_high();
                add_beat(KindOffset, model_pos);
                if (is_high) begin
                    high_held = 1'b1;
                    high_bits = u[9:0];
                end else if (is_low) begin
                    encode_code_point(ReplCp);
                end else begin
                    encode_code_point({5'b0, u});
                end
            end
        end
        if (eot) begin
            flush_held_high();
            add_beat(KindOffset, model_pos);
            high_held = 1'b0;
            high_bits = '0;
            model_pos = '0;
        end
        if (unit_run_q.size() > 0) unit_run_q[unit_run_q.size() - 1].last = 1'b1;
    endfunction

    task automatic push_unit(logic [15:0] u, logic has, logic eot, int n_typed, t_beat typed [8]);
        int unsigned gap;
        t_want_beat  w;
        gap = $urandom_range(0, gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.code_unit   <= u;
        in_if.has_unit    <= has;
        in_if.end_of_text <= eot;
        do @(posedge i_clk); while (!in_if.ready);
        encode_unit(u, has, eot);
        if (n_typed < 0) begin
            foreach (unit_run_q[i]) want_beats_q = {want_beats_q, unit_run_q[i]};
        end else begin
            for (int i = 0; i < n_typed; i++) begin
                w            = '{typed[i].kind, typed[i].value, i == n_typed - 1};
                want_beats_q = {want_beats_q, w};
            end
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (want_beats_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_emit(logic v);
        settle();
        @(negedge i_clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.emit_utf8 <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        emit_on = v;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic add_row(t_row_op op, int emit, logic [15:0] u, int has, int eot, int n,
                           t_beat w0 = '0, t_beat w1 = '0, t_beat w2 = '0, t_beat w3 = '0,
                           t_beat w4 = '0, t_beat w5 = '0, t_beat w6 = '0, t_beat w7 = '0);
        t_dir_row r;
        r.op          = op;
        r.emit        = emit[0];
        r.code_unit   = u;
        r.has_unit    = has[0];
        r.end_of_text = eot[0];
        r.n_want      = n;
        r.want        = '{w0, w1, w2, w3, w4, w5, w6, w7};
        dir_q         = {dir_q, r};
    endtask

    task automatic run_random(int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        int unsigned c;
        int unsigned k;
        sent = 0;
        while (sent < n_items) begin
            text_q.delete();
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_TOP;
            c = $urandom_range(0, 99);
            if (c < 10) begin
                queue_unit(16'($urandom), 1'b0, 1'b1);
            end else begin
                len = $urandom_range(1, 10);
                repeat (len) begin
                    k = $urandom_range(0, 99);
                    if (k < 6) begin
                        queue_unit(16'($urandom), 1'b0, 1'b0);
                    end else if (k < 26) begin
                        queue_unit(16'($urandom_range(0, 'h7F)), 1'b1, 1'b0);
                    end else if (k < 42) begin
                        queue_unit(16'($urandom_range('h80, 'h7FF)), 1'b1, 1'b0);
                    end else if (k < 60) begin
                        if ($urandom_range(0, 1))
                            queue_unit(16'($urandom_range('h800, 'hD7FF)), 1'b1, 1'b0);
                        else
                            queue_unit(16'($urandom_range('hE000, 'hFFFF)), 1'b1, 1'b0);
                    end else if (k < 86) begin
                        queue_unit(16'($urandom_range('hD800, 'hDBFF)), 1'b1, 1'b0);
                        queue_unit(16'($urandom_range('hDC00, 'hDFFF)), 1'b1, 1'b0);
                    end else if (k < 93) begin
                        queue_unit(16'($urandom_range('hD800, 'hDBFF)), 1'b1, 1'b0);
                    end else begin
                        queue_unit(16'($urandom_range('hDC00, 'hDFFF)), 1'b1, 1'b0);
                    end
                end
                // leave some texts open so state carries into the next one
                if (c >= 15) begin
                    if ($urandom_range(0, 1))
                        text_q[text_q.size() - 1].end_of_text = 1'b1;
                    else
                        queue_unit(16'($urandom), 1'b0, 1'b1);
                end
            end
            foreach (text_q[i]) begin
                push_unit(text_q[i].code_unit, text_q[i].has_unit, text_q[i].end_of_text,
                          -1, no_beats);
                if (text_q[i].has_unit || text_q[i].end_of_text) sent++;
            end
            if ($urandom_range(0, 11) == 0) settle();
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left--;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (want_beats_q.size() == 0) begin
                $error("beat with nothing expected: kind %0d value 0x%08h",
                       out_if.kind, out_if.value);
                err_cnt++;
            end else begin
                got_want = want_beats_q.pop_front();
                if (out_if.kind !== got_want.kind) begin
                    $error("kind: expected %0d, got %0d", got_want.kind, out_if.kind);
                    err_cnt++;
                end
                if (out_if.value !== got_want.value) begin
                    $error("value: expected 0x%08h, got 0x%08h", got_want.value, out_if.value);
                    err_cnt++;
                end
                if (out_if.last_of_run !== got_want.last) begin
                    $error("last_of_run: expected %0d, got %0d",
                           got_want.last, out_if.last_of_run);
                    err_cnt++;
                end
            end
            stall_left = $urandom_range(0, stall_max);
            if ($urandom_range(0, 39) == 0) stall_max = (stall_max == 0) ? GAP_TOP : 0;
        end
    end

    initial begin
        logic phase_emit [4];
        phase_emit = '{1'b0, 1'b1, 1'b0, 1'b1};

        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.code_unit   = '0;
        in_if.has_unit    = 1'b0;
        in_if.end_of_text = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.emit_utf8  = 1'b0;
        out_if.ready      = 1'b0;
        foreach (no_beats[i]) no_beats[i] = '0;

        emit_on   = EmitReset;
        high_held = 1'b0;
        high_bits = '0;
        model_pos = '0;

        add_row(ROW_UNIT, 0, 16'h0000, 1, 0, 2, ofs(0), u8('h00));
        add_row(ROW_UNIT, 0, 16'h007F, 1, 0, 2, ofs(1), u8('h7F));
        add_row(ROW_UNIT, 0, 16'h0080, 1, 0, 3, ofs(2), u8('hC2), u8('h80));
        add_row(ROW_UNIT, 0, 16'h07FF, 1, 0, 3, ofs(4), u8('hDF), u8('hBF));
        add_row(ROW_UNIT, 0, 16'h0800, 1, 0, 4, ofs(6), u8('hE0), u8('hA0), u8('h80));
        add_row(ROW_UNIT, 0, 16'hFFFF, 1, 0, 4, ofs(9), u8('hEF), u8('hBF), u8('hBF));
        add_row(ROW_UNIT, 0, 16'hD800, 1, 0, 1, ofs(12));
        add_row(ROW_UNIT, 0, 16'hDC00, 1, 0, 5, ofs(12), u8('hF0), u8('h90), u8('h80), u8('h80));
        add_row(ROW_UNIT, 0, 16'hDBFF, 1, 0, 1, ofs(16));
        add_row(ROW_UNIT, 0, 16'hDFFF, 1, 0, 5, ofs(16), u8('hF4), u8('h8F), u8('hBF), u8('hBF));
        add_row(ROW_UNIT, 0, 16'hDC00, 1, 0, 4, ofs(20), u8('hEF), u8('hBF), u8('hBD));
        add_row(ROW_UNIT, 0, 16'hD834, 1, 0, 1, ofs(23));
        add_row(ROW_UNIT, 0, 16'h0041, 1, 0, 5, u8('hEF), u8('hBF), u8('hBD), ofs(26), u8('h41));
        add_row(ROW_UNIT, 0, 16'hDBFF, 1, 0, 1, ofs(27));
        add_row(ROW_UNIT, 0, 16'hD800, 1, 0, 4, u8('hEF), u8('hBF), u8('hBD), ofs(30));
        add_row(ROW_UNIT, 0, 16'hFFFF, 0, 0, 0);
        add_row(ROW_UNIT, 0, 16'h0000, 0, 1, 4, u8('hEF), u8('hBF), u8('hBD), ofs(33));
        add_row(ROW_UNIT, 0, 16'h0000, 0, 1, 1, ofs(0));
        add_row(ROW_UNIT, 0, 16'hE000, 1, 1, 5, ofs(0), u8('hEE), u8('h80), u8('h80), ofs(3));
        add_row(ROW_UNIT, 0, 16'hD800, 1, 1, 5, ofs(0), u8('hEF), u8('hBF), u8('hBD), ofs(3));
        add_row(ROW_UNIT, 0, 16'hD900, 1, 0, 1, ofs(0));
        add_row(ROW_UNIT, 0, 16'h0800, 1, 1, 8, u8('hEF), u8('hBF), u8('hBD), ofs(3),
                u8('hE0), u8('hA0), u8('h80), ofs(6));
        add_row(ROW_CFG,  0, 16'h0000, 0, 0, 0);
        add_row(ROW_UNIT, 0, 16'h20AC, 1, 0, 1, ofs(0));
        add_row(ROW_UNIT, 0, 16'hD83D, 1, 0, -1);
        add_row(ROW_UNIT, 0, 16'hDE00, 1, 0, -1);
        add_row(ROW_UNIT, 0, 16'h5A5A, 0, 1, -1);
        add_row(ROW_CFG,  1, 16'h0000, 0, 0, 0);
        add_row(ROW_UNIT, 0, 16'h4E2D, 1, 1, -1);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_q[i]) begin
            if (dir_q[i].op == ROW_CFG)
                write_emit(dir_q[i].emit);
            else
                push_unit(dir_q[i].code_unit, dir_q[i].has_unit, dir_q[i].end_of_text,
                          dir_q[i].n_want, dir_q[i].want);
        end

        foreach (phase_emit[p]) begin
            write_emit(phase_emit[p]);
            run_random(64);
        end

        settle();
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
